@@ hdl/previous_greater_element_defines.svh @@
// assertion helpers shared by the previous greater element modules
// every macro expects i_clk and i_rst_n in scope
`ifndef PREVIOUS_GREATER_ELEMENT_DEFINES_SVH
`define PREVIOUS_GREATER_ELEMENT_DEFINES_SVH

// condition holds at every clock edge outside reset
`define PGE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PGE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/pge_pkg.sv @@
`timescale 1ns / 1ps

package pge_pkg;

    // fixed field widths
    localparam int HEIGHT_IN_W = 32;
    localparam int POS_W       = 11;

    // controller to datapath
    typedef struct packed {
        logic load_item;  // capture the incoming beat
        logic pop;        // drop the top entry
        logic finish;     // register result, push, update counters
        logic use_ram;    // top of stack comes from the memory read data
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pop_hit;    // top entry is lower than the current height
        logic pop_reads;  // a pop leaves entries behind, so the next top is read
    } t_status;

endpackage

@@ hdl/pge_ram.sv @@
`timescale 1ns / 1ps

module pge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pge_ctrl.sv @@
`timescale 1ns / 1ps
`include "previous_greater_element_defines.svh"

module pge_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  pge_pkg::t_status i_status,
    output pge_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_POP  = 3'b100
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          out_free;
    pge_pkg::t_cmd cmd;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        cmd           = '0;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP, S_POP: begin
                cmd.use_ram = (r_state == S_POP);
                if (i_status.pop_hit) begin
                    cmd.pop = 1'b1;
                    n_state = i_status.pop_reads ? S_POP : S_CMP;
                end else if (out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    // top entry already latched, wait for the output slot
                    n_state = S_CMP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `PGE_ASSERT_IMPL(a_finish_slot, cmd.finish, !r_out_valid || i_out_ready, "result overwritten")
    `PGE_ASSERT_IMPL(a_valid_source, $rose(r_out_valid), $past(cmd.finish), "result without finish")
    `PGE_ASSERT_IMPL(a_ram_after_pop, cmd.use_ram, $past(cmd.pop), "stack read without pop")

endmodule

@@ hdl/pge_datapath.sv @@
`timescale 1ns / 1ps
`include "previous_greater_element_defines.svh"

module pge_datapath #(
    parameter int MAX_ITEMS   = 1024,
    parameter int HEIGHT_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [pge_pkg::HEIGHT_IN_W-1:0]  i_height,
    input  logic                             i_last_in_sequence,
    input  pge_pkg::t_cmd                    i_cmd,
    output pge_pkg::t_status                 o_status,
    output logic [pge_pkg::POS_W-1:0]        o_nearest_position,
    output logic                             o_overflow
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int EW = HEIGHT_BITS + CW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    logic [HEIGHT_BITS-1:0] r_h;
    logic                   r_last;
    logic [HEIGHT_BITS-1:0] r_top_h;
    logic [CW-1:0]          r_top_p;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_items;
    logic [pge_pkg::POS_W-1:0] r_pos;
    logic                   r_ovf;

    logic [HEIGHT_BITS+pge_pkg::HEIGHT_IN_W-1:0] h_ext;
    logic [CW+pge_pkg::POS_W-1:0]                pos_ext;
    logic [EW-1:0]          ram_rdata;
    logic [HEIGHT_BITS-1:0] ram_h;
    logic [CW-1:0]          ram_p;
    logic [HEIGHT_BITS-1:0] cur_h;
    logic [CW-1:0]          cur_p;
    logic [CW-1:0]          items_inc;
    logic [CW-1:0]          count_m2;
    logic                   full;
    logic                   stack_empty;
    logic                   ram_re;
    logic                   ram_we;

    // keep the low HEIGHT_BITS of the input, zero extended if wider
    assign h_ext = {{HEIGHT_BITS{1'b0}}, i_height};

    assign ram_h = ram_rdata[EW-1:CW];
    assign ram_p = ram_rdata[CW-1:0];
    assign cur_h = i_cmd.use_ram ? ram_h : r_top_h;
    assign cur_p = i_cmd.use_ram ? ram_p : r_top_p;

    assign full        = (r_items == MAX_CNT);
    assign stack_empty = (r_count == '0);
    assign items_inc   = r_items + CW'(1);
    assign count_m2    = r_count - CW'(2);

    assign o_status.pop_hit   = !full && !stack_empty && (cur_h < r_h);
    assign o_status.pop_reads = (r_count != CW'(1));

    assign ram_re = i_cmd.pop && o_status.pop_reads;
    assign ram_we = i_cmd.finish && !full;

    assign pos_ext = {{pge_pkg::POS_W{1'b0}}, cur_p};

    pge_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ITEMS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_h, items_inc}),
        .i_re    (ram_re),
        .i_raddr (count_m2[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_items <= '0;
        end else begin
            if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_count <= '0;
                    r_items <= '0;
                end else if (!full) begin
                    r_count <= r_count + CW'(1);
                    r_items <= items_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_h    <= h_ext[HEIGHT_BITS-1:0];
            r_last <= i_last_in_sequence;
        end
        // the pushed beat becomes the new top, else keep the entry just read
        if (i_cmd.finish && !full) begin
            r_top_h <= r_h;
            r_top_p <= items_inc;
        end else if (i_cmd.use_ram) begin
            r_top_h <= ram_h;
            r_top_p <= ram_p;
        end
        if (i_cmd.finish) begin
            r_ovf <= full;
            r_pos <= (full || stack_empty) ? '0 : pos_ext[pge_pkg::POS_W-1:0];
        end
    end

    assign o_nearest_position = r_pos;
    assign o_overflow         = r_ovf;

    `PGE_ASSERT_ALWAYS(a_stack_le_items, r_count <= r_items, "stack deeper than sequence")
    `PGE_ASSERT_ALWAYS(a_items_bound, r_items <= MAX_CNT, "item count past capacity")
    `PGE_ASSERT_IMPL(a_no_pop_when_full, full, !o_status.pop_hit, "pop on overflow item")

endmodule

@@ hdl/previous_greater_element.sv @@
`timescale 1ns / 1ps
// previous greater element: for every height beat, returns the 1-based position of the
// nearest earlier beat of the same sequence whose height is greater than or equal to it,
// or 0 when there is none. a monotonic stack in a single-port-read memory holds the
// candidates, with the top entry cached in flops. an item is captured, then compared,
// with a pop step for every stack entry it pops, since the stack memory delivers one
// registered read per cycle, then pushed once the output register frees up; each item
// pops at most what earlier items pushed. the result sits in an output register, so the
// next beat is taken while it waits. the beat flagged last_in_sequence clears the stack
// and the position counter after it is answered. once MAX_ITEMS beats of a sequence are
// in, further beats return position 0 with overflow set and touch no state.
// only the low HEIGHT_BITS of the height are compared. no clearing pass after reset.

module previous_greater_element #(
    parameter int MAX_ITEMS   = 1024,
    parameter int HEIGHT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [pge_pkg::HEIGHT_IN_W-1:0] i_height,
    input  logic                            i_last_in_sequence,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pge_pkg::POS_W-1:0]       o_nearest_position,
    output logic                            o_overflow
);

    // command and status between sequencer and stack datapath
    pge_pkg::t_cmd    cmd;
    pge_pkg::t_status status;

    // sequencer: capture, pop loop, finish when the output register frees up
    pge_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // stack memory, cached top, counters and result register
    pge_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_height           (i_height),
        .i_last_in_sequence (i_last_in_sequence),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_nearest_position (o_nearest_position),
        .o_overflow         (o_overflow)
    );

endmodule
